// ===== hw/rtl/sgi_pkg.sv =====
// Shared widths, register codes, mode codes and types of the sepia / grey / invert filter.
package sgi_pkg;

	localparam int CH_W      = 8;
	localparam int MODE_W    = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 2;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT_ENABLE = 1'b1;

	// filter modes; code 3 behaves as none
	localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SEPIA = 2'd1;
	localparam logic [MODE_W-1:0] MODE_GREY  = 2'd2;

	// sepia weights, Q10
	localparam int WGT_W = 10;
	localparam logic [WGT_W-1:0] W_RR = 10'd402;
	localparam logic [WGT_W-1:0] W_RG = 10'd787;
	localparam logic [WGT_W-1:0] W_RB = 10'd194;
	localparam logic [WGT_W-1:0] W_GR = 10'd357;
	localparam logic [WGT_W-1:0] W_GG = 10'd702;
	localparam logic [WGT_W-1:0] W_GB = 10'd172;
	localparam logic [WGT_W-1:0] W_BR = 10'd279;
	localparam logic [WGT_W-1:0] W_BG = 10'd547;
	localparam logic [WGT_W-1:0] W_BB = 10'd134;

	// divide by 3 via reciprocal: floor(s*683 >> 11) is exact for s < 2048
	localparam logic [10:0] RECIP3 = 11'd683;

	typedef struct packed {
		logic [MODE_W-1:0] filter_mode;
		logic              invert_enable;
	} cfg_t;

	typedef struct packed {
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
		logic            last;
	} pixel_t;

endpackage

// ===== hw/rtl/sgi_cfg_if.sv =====
// Config write channel: valid/ready with register index and data.
interface sgi_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [sgi_pkg::CFG_IDX_W-1:0]  index;
	logic [sgi_pkg::CFG_DAT_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/sgi_pix_in_if.sv =====
// Input pixel channel: valid/ready with the three channels and last marker.
interface sgi_pix_in_if;
	logic                      valid;
	logic                      ready;
	logic [sgi_pkg::CH_W-1:0]  blue_in;
	logic [sgi_pkg::CH_W-1:0]  green_in;
	logic [sgi_pkg::CH_W-1:0]  red_in;
	logic                      last_in;

	modport source (output valid, blue_in, green_in, red_in, last_in, input ready);
	modport sink   (input valid, blue_in, green_in, red_in, last_in, output ready);
endinterface

// ===== hw/rtl/sgi_pix_out_if.sv =====
// Output pixel channel: valid/ready with the filtered channels and last marker.
interface sgi_pix_out_if;
	logic                      valid;
	logic                      ready;
	logic [sgi_pkg::CH_W-1:0]  blue_out;
	logic [sgi_pkg::CH_W-1:0]  green_out;
	logic [sgi_pkg::CH_W-1:0]  red_out;
	logic                      last_out;

	modport source (output valid, blue_out, green_out, red_out, last_out, input ready);
	modport sink   (input valid, blue_out, green_out, red_out, last_out, output ready);
endinterface

// ===== hw/rtl/sgi_cfg_regs.sv =====
// Config register file: filter mode and invert enable.
module sgi_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	sgi_cfg_if.sink       cfg,
	output sgi_pkg::cfg_t cfg_q
);
	import sgi_pkg::*;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_FILTER_MODE: begin
					cfg_q.filter_mode <= cfg.data[MODE_W-1:0];
				end
				REG_INVERT_ENABLE: begin
					cfg_q.invert_enable <= cfg.data[0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/sgi_pixel_math.sv =====
// Per-pixel datapath: optional invert, then sepia, greyscale or pass-through.
module sgi_pixel_math (
	input  sgi_pkg::cfg_t   cfg,
	input  sgi_pkg::pixel_t pix,
	output sgi_pkg::pixel_t res
);
	import sgi_pkg::*;

	// weighted sum, floor by 1024, clamp at 255
	function automatic logic [CH_W-1:0] sepia_ch(
		input logic [CH_W-1:0]  r,
		input logic [CH_W-1:0]  g,
		input logic [CH_W-1:0]  b,
		input logic [WGT_W-1:0] wr,
		input logic [WGT_W-1:0] wg,
		input logic [WGT_W-1:0] wb
	);
		logic [18:0] sum;
		logic [8:0]  q;
		sum = 19'(wr) * 19'(r) + 19'(wg) * 19'(g) + 19'(wb) * 19'(b);
		q   = sum[18:10];
		sepia_ch = q[8] ? 8'hFF : q[7:0];
	endfunction

	logic [CH_W-1:0] r, g, b;
	logic [9:0]      grey_sum;
	logic [20:0]     grey_prod;
	logic [CH_W-1:0] grey;

	always_comb begin
		r = cfg.invert_enable ? ~pix.red   : pix.red;
		g = cfg.invert_enable ? ~pix.green : pix.green;
		b = cfg.invert_enable ? ~pix.blue  : pix.blue;

		grey_sum  = 10'(r) + 10'(g) + 10'(b);
		grey_prod = 21'(grey_sum) * 21'(RECIP3);
		grey      = grey_prod[18:11];

		res.last = pix.last;
		case (cfg.filter_mode)
			MODE_SEPIA: begin
				res.red   = sepia_ch(r, g, b, W_RR, W_RG, W_RB);
				res.green = sepia_ch(r, g, b, W_GR, W_GG, W_GB);
				res.blue  = sepia_ch(r, g, b, W_BR, W_BG, W_BB);
			end
			MODE_GREY: begin
				res.red   = grey;
				res.green = grey;
				res.blue  = grey;
			end
			MODE_NONE: begin
				res.red   = r;
				res.green = g;
				res.blue  = b;
			end
			default: begin
				res.red   = r;
				res.green = g;
				res.blue  = b;
			end
		endcase
	end

endmodule

// ===== hw/rtl/rgb_sepia_grey_invert_filter_unit.sv =====
// Top level: sepia / greyscale / invert pixel filter with input and result registers.
//
//  channel  | dir | handshake     | word
//  ---------+-----+---------------+--------------------------------------------
//  cfg      | in  | valid / ready | index (0 filter_mode, 1 invert_enable), data
//  pixel    | in  | valid / ready | blue_in, green_in, red_in, last_in
//  result   | out | valid / ready | blue_out, green_out, red_out, last_out
//
//  One pixel word per cycle sustained while result.ready stays high; a taken word passes
//  the input register (s1) and then the result register (s2) before it leaves.
//  Stage 1 is the input register, the math sits between it and the result register (s2).
//  Both stages advance together whenever the result register is empty or being taken;
//  an empty stage 1 also takes a new word while a finished result still waits.
//  cfg.ready is always high; registers reset to mode none, invert off.
//  arst_n clears the stage valid bits and the config registers.
module rgb_sepia_grey_invert_filter_unit (
	input  logic           clk,
	input  logic           arst_n,
	sgi_cfg_if.sink        cfg,
	sgi_pix_in_if.sink     pixel,
	sgi_pix_out_if.source  result
);
	import sgi_pkg::*;

	cfg_t   cfg_q;
	pixel_t pix_s1;
	logic   valid_s1;
	pixel_t math_res;
	pixel_t res_s2;
	logic   valid_s2;
	logic   advance;

	sgi_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_q  (cfg_q)
	);

	sgi_pixel_math u_math (
		.cfg (cfg_q),
		.pix (pix_s1),
		.res (math_res)
	);

	// whole pipe moves when the result slot is free or being drained
	assign advance     = !valid_s2 || result.ready;
	assign pixel.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (pixel.ready) begin
				valid_s1 <= pixel.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (pixel.ready && pixel.valid) begin
			pix_s1.blue  <= pixel.blue_in;
			pix_s1.green <= pixel.green_in;
			pix_s1.red   <= pixel.red_in;
			pix_s1.last  <= pixel.last_in;
		end
		if (advance && valid_s1) begin
			res_s2 <= math_res;
		end
	end

	assign result.valid     = valid_s2;
	assign result.blue_out  = res_s2.blue;
	assign result.green_out = res_s2.green;
	assign result.red_out   = res_s2.red;
	assign result.last_out  = res_s2.last;

	// back-pressure only when both stages hold data and the result is stuck
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel.ready |-> (valid_s1 && valid_s2 && !result.ready))
		else $error("input stalled while a stage is free");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel.valid && pixel.ready) |=> valid_s1)
		else $error("accepted word lost before stage 1");

	a_s1_moves_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s1) |=> valid_s2)
		else $error("stage 1 word did not reach result register");

	// sepia weights are ordered per column, so red >= green >= blue
	a_sepia_order: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s1 && cfg_q.filter_mode == MODE_SEPIA) |=>
		(res_s2.red >= res_s2.green && res_s2.green >= res_s2.blue))
		else $error("sepia channel ordering violated");

endmodule
